// ----- hw/rtl/rkc_pkg.sv -----
// Shared types and constants for the RGB kernel convolution core.
// Holds register indexes, reset values, size limits and the sequencer state type.
// Also the input function codes and the divide response type; no dependencies.
package rkc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int KMAX_DEF      = 5;

  // Frame height limit and counter widths that follow from it.
  localparam int HEIGHT_LIMIT = 4096;
  localparam int HW           = 13;
  localparam int RW           = 12;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_KCOLS   = 3'd2;
  localparam logic [2:0] REG_KROWS   = 3'd3;
  localparam logic [2:0] REG_OFFSET  = 3'd4;
  localparam logic [2:0] REG_DIVISOR = 3'd5;

  // Register reset values.
  localparam logic [10:0] WIDTH_RST   = 11'd1024;
  localparam logic [12:0] HEIGHT_RST  = 13'd1024;
  localparam logic [2:0]  KSIZE_RST   = 3'd3;
  localparam logic [10:0] OFFSET_RST  = 11'd0;
  localparam logic [15:0] DIVISOR_RST = 16'd256;

  // Input function codes.
  localparam logic FUNC_COEF  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Sequencer states.
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ROW0  = 10'b0000000010,
    ST_ROW1  = 10'b0000000100,
    ST_ROW2  = 10'b0000001000,
    ST_ROW3  = 10'b0000010000,
    ST_TAP   = 10'b0000100000,
    ST_DRAIN = 10'b0001000000,
    ST_DIVST = 10'b0010000000,
    ST_DIVW  = 10'b0100000000,
    ST_PUSH  = 10'b1000000000
  } seq_state_t;

  // Response from the divide unit to the sequencer.
  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } div_rsp_t;

endpackage

// ----- hw/rtl/rkc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the coefficient store and the line store; no dependencies.
module rkc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rkc_div.sv -----
// Floor divide of a signed kernel sum, then offset add and clamp to 0..255.
// One quotient bit per cycle; depends on rkc_pkg for the response struct.
module rkc_div #(
  parameter int AW = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] dividend,
  input  logic [15:0]          divisor,
  input  logic signed [10:0]   offset,
  output rkc_pkg::div_rsp_t    rsp
);

  localparam int CNW = $clog2(AW + 1);

  logic              busy_r, busy_nxt;
  logic [CNW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]     mag_r, mag_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [15:0]       d_r, d_nxt;
  logic              neg_r, neg_nxt;
  logic signed [10:0] off_r, off_nxt;
  logic              done_r, done_nxt;
  logic [7:0]        val_r, val_nxt;

  logic [16:0]            rem_sh;
  logic                   ge;
  logic signed [AW:0]     qpos;
  logic signed [AW:0]     qfl;
  logic signed [AW+1:0]   qo;

  // One restoring step, and the signed floor with offset and clamp.
  always_comb begin
    rem_sh = {rem_r, mag_r[AW-1]};
    ge     = (rem_sh >= {1'b0, d_r});
    qpos   = $signed({1'b0, mag_r});
    if (neg_r) begin
      qfl = -qpos - $signed({{AW{1'b0}}, (rem_r != 16'd0)});
    end else begin
      qfl = qpos;
    end
    qo = $signed({qfl[AW], qfl}) + $signed({{(AW + 2 - 11){off_r[10]}}, off_r});
  end

  // Divider sequencing.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    off_nxt  = off_r;
    done_nxt = 1'b0;
    val_nxt  = val_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[AW-1];
      mag_nxt  = dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
      rem_nxt  = '0;
      d_nxt    = divisor;
      off_nxt  = offset;
    end else if (busy_r) begin
      if (cnt_r == CNW'(AW)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (qo < 0) begin
          val_nxt = 8'd0;
        end else if (qo > 255) begin
          val_nxt = 8'd255;
        end else begin
          val_nxt = qo[7:0];
        end
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        mag_nxt = {mag_r[AW-2:0], ge};
        rem_nxt = ge ? 16'(rem_sh - {1'b0, d_r}) : rem_sh[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
    off_r <= off_nxt;
    val_r <= val_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = val_r;

endmodule

// ----- hw/rtl/rgb_kernel_convolution_core.sv -----
// RGB kernel convolution core: one result pixel per pixel request, none per coefficient load.
// A coefficient load with an index below KMAX*KMAX is written to the coefficient store when accepted.
// An edge pass-through pixel goes through the push state to the output register. A filtered pixel's time
// is set by the tap loop over the line store read port and the bit-serial divider (AW = 30 at KMAX 5).
// One request is in work at a time. Reset clears the configuration registers, the sequencer state, the
// position counters and the output valid flag; the coefficient and line stores are not cleared.
module rgb_kernel_convolution_core #(
  parameter int MAX_WIDTH = rkc_pkg::MAX_WIDTH_DEF,
  parameter int KMAX      = rkc_pkg::KMAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [4:0]  in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_end,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int KW   = $clog2(KMAX + 1);
  localparam int KSW  = (KMAX > 1) ? $clog2(KMAX) : 1;
  localparam int CAW  = (KMAX * KMAX > 1) ? $clog2(KMAX * KMAX) : 1;
  localparam int LAW  = $clog2(KMAX * MAX_WIDTH);
  localparam int AW   = 8 + 16 + $clog2(KMAX * KMAX) + 1;
  localparam int YW   = rkc_pkg::HW;
  localparam int RS   = YW + 4;
  localparam int RECIP = ((1 << RS) + KMAX - 1) / KMAX;
  localparam int PW   = YW + RS + 1;
  // Store position that a coordinate of -1 reduces to as an unsigned 32-bit value.
  localparam int XNEG = int'(64'hFFFF_FFFF % MAX_WIDTH);
  localparam int YNEG = int'(64'hFFFF_FFFF % KMAX);

  // Configuration registers.
  logic [10:0]        width_r;
  logic [12:0]        height_r;
  logic [2:0]         kcols_r;
  logic [2:0]         krows_r;
  logic signed [10:0] offset_r;
  logic [15:0]        divisor_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= rkc_pkg::WIDTH_RST;
      height_r  <= rkc_pkg::HEIGHT_RST;
      kcols_r   <= rkc_pkg::KSIZE_RST;
      krows_r   <= rkc_pkg::KSIZE_RST;
      offset_r  <= rkc_pkg::OFFSET_RST;
      divisor_r <= rkc_pkg::DIVISOR_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        rkc_pkg::REG_WIDTH:   width_r   <= pwdata[10:0];
        rkc_pkg::REG_HEIGHT:  height_r  <= pwdata[12:0];
        rkc_pkg::REG_KCOLS:   kcols_r   <= pwdata[2:0];
        rkc_pkg::REG_KROWS:   krows_r   <= pwdata[2:0];
        rkc_pkg::REG_OFFSET:  offset_r  <= pwdata[10:0];
        rkc_pkg::REG_DIVISOR: divisor_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      rkc_pkg::REG_WIDTH:   prdata = {21'd0, width_r};
      rkc_pkg::REG_HEIGHT:  prdata = {19'd0, height_r};
      rkc_pkg::REG_KCOLS:   prdata = {29'd0, kcols_r};
      rkc_pkg::REG_KROWS:   prdata = {29'd0, krows_r};
      rkc_pkg::REG_OFFSET:  prdata = {21'd0, offset_r};
      rkc_pkg::REG_DIVISOR: prdata = {16'd0, divisor_r};
      default:              prdata = 32'd0;
    endcase
  end

  // Effective sizes with out-of-range values saturated.
  logic [WW-1:0]  w_eff;
  logic [YW-1:0]  h_eff;
  logic [KW-1:0]  kc_eff, kr_eff, xr, yr;
  logic [15:0]    d_eff;

  always_comb begin
    if (width_r == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == 13'd0) begin
      h_eff = YW'(1);
    end else if (32'(height_r) > rkc_pkg::HEIGHT_LIMIT) begin
      h_eff = YW'(rkc_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = height_r;
    end
    if (kcols_r == 3'd0) begin
      kc_eff = KW'(1);
    end else if (32'(kcols_r) > KMAX) begin
      kc_eff = KW'(KMAX);
    end else begin
      kc_eff = KW'(kcols_r);
    end
    if (krows_r == 3'd0) begin
      kr_eff = KW'(1);
    end else if (32'(krows_r) > KMAX) begin
      kr_eff = KW'(KMAX);
    end else begin
      kr_eff = KW'(krows_r);
    end
    xr    = kc_eff >> 1;
    yr    = kr_eff >> 1;
    d_eff = (divisor_r == 16'd0) ? 16'd1 : divisor_r;
  end

  // Sequencer and position registers.
  rkc_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]       col_r;
  logic [rkc_pkg::RW-1:0] row_r;
  logic [KSW-1:0]      row_mod_r;
  logic [CW-1:0]       x_r;
  logic [rkc_pkg::RW-1:0] y_r;
  logic                fe_r;
  logic [KW-1:0]       i_r, j_r;
  logic [YW-1:0]       yv_r;
  logic [YW-1:0]       q_r;
  logic [KSW-1:0]      rem_r;
  logic [LAW-1:0]      base_r;
  logic [1:0]          ch_r;
  logic [7:0]          res_r [3];

  logic accept, acc_pix, acc_coef, pass, col_wrap, row_wrap;
  logic signed [YW+1:0] ys;
  logic [YW-1:0]        ymax, yv;
  logic signed [CW+2:0] xs;
  logic [WW-1:0]        xmax;
  logic [CW-1:0]        xv;
  logic [PW-1:0]        qprod;
  logic last_i, last_j, out_free;

  assign in_stall = (state_r != rkc_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign acc_pix  = accept && (in_func == rkc_pkg::FUNC_PIXEL);
  assign acc_coef = accept && (in_func == rkc_pkg::FUNC_COEF);
  assign pass     = (32'(col_r) < 32'(xr)) || (32'(row_r) < 32'(yr));
  assign col_wrap = (32'(col_r) + 1 >= 32'(w_eff));
  assign row_wrap = (32'(row_r) + 1 >= 32'(h_eff));
  assign last_i   = (i_r == kc_eff - 1'b1);
  assign last_j   = (j_r == kr_eff - 1'b1);
  assign out_free = !out_valid || !out_stall;

  // Window coordinates with edge clamping. When the upper limit falls below zero the
  // coordinate is -1, which lands on the store position that -1 reduces to.
  always_comb begin
    ys   = $signed({2'b00, 1'b0, y_r}) - $signed((YW + 2)'({yr, 1'b0}))
           + $signed((YW + 2)'(j_r));
    ymax = h_eff - YW'(yr);
    if (h_eff < YW'(yr)) begin
      yv = YW'(YNEG);
    end else if (ys < 0) begin
      yv = '0;
    end else if (ys > $signed({2'b00, ymax})) begin
      yv = ymax;
    end else begin
      yv = ys[YW-1:0];
    end
    xs   = $signed({3'b000, x_r}) - $signed((CW + 3)'({xr, 1'b0}))
           + $signed((CW + 3)'(i_r));
    xmax = w_eff - WW'(xr);
    if (w_eff < WW'(xr)) begin
      xv = CW'(XNEG);
    end else if (xs < 0) begin
      xv = '0;
    end else if (xs > $signed((CW + 3)'(xmax))) begin
      xv = xmax[CW-1:0];
    end else begin
      xv = xs[CW-1:0];
    end
    qprod = PW'(yv_r) * PW'(RECIP);
  end

  // Stores.
  logic             lwe, cwe;
  logic [LAW-1:0]   lwaddr, lraddr;
  logic [CAW-1:0]   cwaddr, craddr;
  logic [23:0]      lrdata;
  logic [15:0]      crdata;
  logic [31:0]      cidx;

  assign cidx   = 32'(in_coef_index);
  assign cwe    = acc_coef && (cidx < KMAX * KMAX);
  assign cwaddr = cidx[CAW-1:0];
  assign lwe    = acc_pix;
  assign lwaddr = LAW'(32'(row_mod_r) * MAX_WIDTH + 32'(col_r));
  assign lraddr = base_r + LAW'(xv);
  assign craddr = CAW'(32'(j_r) * KMAX + 32'(i_r));

  rkc_ram #(.WIDTH(16), .DEPTH(KMAX * KMAX)) u_coef_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (cwaddr),
    .wdata (in_coef_value),
    .raddr (craddr),
    .rdata (crdata)
  );

  rkc_ram #(.WIDTH(24), .DEPTH(KMAX * MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (lwaddr),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .raddr (lraddr),
    .rdata (lrdata)
  );

  // Multiply-accumulate pipeline behind the store reads.
  logic                 iss_vld_r, prod_vld_r;
  logic signed [24:0]   prod_r [3];
  logic signed [AW-1:0] acc_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      iss_vld_r  <= (state_r == rkc_pkg::ST_TAP);
      prod_vld_r <= iss_vld_r;
    end
    prod_r[0] <= $signed({1'b0, lrdata[23:16]}) * $signed(crdata);
    prod_r[1] <= $signed({1'b0, lrdata[15:8]}) * $signed(crdata);
    prod_r[2] <= $signed({1'b0, lrdata[7:0]}) * $signed(crdata);
    for (int c = 0; c < 3; c++) begin
      if (acc_pix) begin
        acc_r[c] <= '0;
      end else if (prod_vld_r) begin
        acc_r[c] <= acc_r[c] + AW'(prod_r[c]);
      end
    end
  end

  // Shared divide unit.
  logic                 div_start;
  logic signed [AW-1:0] div_in;
  rkc_pkg::div_rsp_t    div_rsp;

  assign div_start = (state_r == rkc_pkg::ST_DIVST);
  assign div_in    = acc_r[ch_r];

  rkc_div #(.AW(AW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (d_eff),
    .offset   (offset_r),
    .rsp      (div_rsp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rkc_pkg::ST_IDLE:  if (acc_pix) state_nxt = pass ? rkc_pkg::ST_PUSH : rkc_pkg::ST_ROW0;
      rkc_pkg::ST_ROW0:  state_nxt = rkc_pkg::ST_ROW1;
      rkc_pkg::ST_ROW1:  state_nxt = rkc_pkg::ST_ROW2;
      rkc_pkg::ST_ROW2:  state_nxt = rkc_pkg::ST_ROW3;
      rkc_pkg::ST_ROW3:  state_nxt = rkc_pkg::ST_TAP;
      rkc_pkg::ST_TAP: begin
        if (last_i) begin
          state_nxt = last_j ? rkc_pkg::ST_DRAIN : rkc_pkg::ST_ROW0;
        end
      end
      rkc_pkg::ST_DRAIN: begin
        if (!iss_vld_r && !prod_vld_r) state_nxt = rkc_pkg::ST_DIVST;
      end
      rkc_pkg::ST_DIVST: state_nxt = rkc_pkg::ST_DIVW;
      rkc_pkg::ST_DIVW: begin
        if (div_rsp.done) state_nxt = (ch_r == 2'd2) ? rkc_pkg::ST_PUSH : rkc_pkg::ST_DIVST;
      end
      rkc_pkg::ST_PUSH:  if (out_free) state_nxt = rkc_pkg::ST_IDLE;
      default:           state_nxt = rkc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer registers, position counters and tap loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rkc_pkg::ST_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      row_mod_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_pix) begin
        if (col_wrap) begin
          col_r <= '0;
          if (row_wrap) begin
            row_r     <= '0;
            row_mod_r <= '0;
          end else begin
            row_r     <= row_r + 1'b1;
            row_mod_r <= (32'(row_mod_r) == KMAX - 1) ? '0 : row_mod_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
    if (acc_pix) begin
      x_r      <= col_r;
      y_r      <= row_r;
      fe_r     <= col_wrap && row_wrap;
      i_r      <= '0;
      j_r      <= '0;
      ch_r     <= '0;
      res_r[0] <= in_red_in;
      res_r[1] <= in_green_in;
      res_r[2] <= in_blue_in;
    end
    // Row setup: clamp, reduce modulo the ring depth, form the row base.
    if (state_r == rkc_pkg::ST_ROW0) yv_r <= yv;
    if (state_r == rkc_pkg::ST_ROW1) q_r <= qprod[RS +: YW];
    if (state_r == rkc_pkg::ST_ROW2) rem_r <= KSW'(32'(yv_r) - 32'(q_r) * KMAX);
    if (state_r == rkc_pkg::ST_ROW3) base_r <= LAW'(32'(rem_r) * MAX_WIDTH);
    if (state_r == rkc_pkg::ST_TAP) begin
      if (last_i) begin
        i_r <= '0;
        j_r <= j_r + 1'b1;
      end else begin
        i_r <= i_r + 1'b1;
      end
    end
    if (state_r == rkc_pkg::ST_DIVW && div_rsp.done) begin
      res_r[ch_r] <= div_rsp.value;
      ch_r        <= ch_r + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == rkc_pkg::ST_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state_r == rkc_pkg::ST_PUSH && out_free) begin
      out_red_out   <= res_r[0];
      out_green_out <= res_r[1];
      out_blue_out  <= res_r[2];
      out_frame_end <= fe_r;
    end
  end

endmodule
